>>> sv/fcp_pkg.sv
// Shared types and constants for the framed command parser.
// No dependencies; used by fcp_store.sv and framed_command_parser.sv.
package fcp_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 5;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W = 1;

  // Length limit: lengths below it fit the 5-bit field and the store
  localparam int LEN_LIMIT_MAX = 32;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h66;

  // Accepted function codes
  localparam logic [BYTE_W-1:0] FUNC_READ   = 8'h01;
  localparam logic [BYTE_W-1:0] FUNC_WRITE  = 8'h02;
  localparam logic [BYTE_W-1:0] FUNC_MOVE   = 8'h03;
  localparam logic [BYTE_W-1:0] FUNC_SERVO  = 8'h11;

  function automatic logic func_valid(input logic [BYTE_W-1:0] code);
    return (code == FUNC_READ) || (code == FUNC_WRITE) ||
           (code == FUNC_MOVE) || (code == FUNC_SERVO);
  endfunction

endpackage

>>> sv/fcp_store.sv
// Payload byte store for the framed command parser: one write port and one
// registered read port. Depends on fcp_pkg.
module fcp_store #(
  parameter int DEPTH  = 31,
  parameter int ADDR_W = 5
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [fcp_pkg::BYTE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [fcp_pkg::BYTE_W-1:0]  rd_data
);

  logic [fcp_pkg::BYTE_W-1:0] mem [DEPTH];

  // Write one payload byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/framed_command_parser.sv
// Framed command parser top level: byte stream in, per-payload-byte results out.
// Depends on fcp_pkg and fcp_store.
//
// Bytes arrive on the slave stream one per request; each byte is accepted,
// then makes one pass through the shared compare and add unit. The frame is
// two sync bytes, a function code (0x01, 0x02, 0x03 or 0x11), a length below
// min(PAYLOAD_CAPACITY, 32), the payload and a checksum equal to the inverted
// 8-bit sum of function, length and payload. On a matching checksum with a
// payload, one result per payload byte leaves on the master stream, each read
// through the single read port of the payload store before it loads; a bad
// checksum or an empty payload gives one result with zero payload. No input
// byte is taken while results of a frame are being read out, nor while a
// frame's last result waits and the next byte would be a checksum.
module framed_command_parser #(
  parameter int PAYLOAD_CAPACITY = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // rx_byte [7:0]
  input  logic [fcp_pkg::IN_DATA_W-1:0]         s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // function_code [7:0], payload_length [12:8], payload_byte [20:13],
  // byte_position [25:21], zero fill [31:26]
  output logic [fcp_pkg::OUT_DATA_W-1:0]        m_tdata,
  // checksum_ok [0]
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fcp_pkg::BYTE_W-1:0]            cfg_data
);

  localparam int LEN_LIMIT = (PAYLOAD_CAPACITY > fcp_pkg::LEN_LIMIT_MAX) ?
                             fcp_pkg::LEN_LIMIT_MAX : PAYLOAD_CAPACITY;
  localparam int STORE_DEPTH = LEN_LIMIT - 1;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [fcp_pkg::BYTE_W:0] LIMIT_CMP = (fcp_pkg::BYTE_W+1)'(LEN_LIMIT);
  localparam int PAD_W = fcp_pkg::OUT_DATA_W - 2 * fcp_pkg::BYTE_W - 2 * fcp_pkg::LEN_W;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_FUNC  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARSE,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t                        state;
  phase_t                        phase;
  logic [fcp_pkg::BYTE_W-1:0]    sync_first;
  logic [fcp_pkg::BYTE_W-1:0]    sync_second;
  logic [fcp_pkg::BYTE_W-1:0]    rx_byte;
  logic [fcp_pkg::BYTE_W-1:0]    frame_function;
  logic [fcp_pkg::LEN_W-1:0]     frame_length;
  logic [fcp_pkg::LEN_W-1:0]     payload_count;
  logic [fcp_pkg::BYTE_W-1:0]    running_sum;
  logic [fcp_pkg::LEN_W-1:0]     emit_index;
  logic                          emit_single;
  logic                          frame_ok;

  // Output register fields
  logic [fcp_pkg::BYTE_W-1:0]    out_function;
  logic [fcp_pkg::LEN_W-1:0]     out_length;
  logic [fcp_pkg::BYTE_W-1:0]    out_payload;
  logic [fcp_pkg::LEN_W-1:0]     out_position;
  logic                          out_ok;
  logic                          out_last;
  logic                          out_valid;

  // Shared unit operands and results
  logic [fcp_pkg::BYTE_W-1:0]    cmp_ref;
  logic                          cmp_match;
  logic [fcp_pkg::BYTE_W-1:0]    add_base;
  logic [fcp_pkg::BYTE_W-1:0]    sum_next;
  logic [fcp_pkg::LEN_W-1:0]     count_next;
  logic                          len_too_big;
  logic                          out_free;
  logic                          emit_last;

  logic                          wr_en;
  logic                          rd_en;
  logic [fcp_pkg::BYTE_W-1:0]    rd_data;

  // Select the compare reference for the current phase
  always_comb begin
    case (phase)
      PH_SYNC2: cmp_ref = sync_second;
      PH_CSUM:  cmp_ref = ~running_sum;
      default:  cmp_ref = sync_first;
    endcase
  end

  // Shared compare and add unit
  assign cmp_match   = (rx_byte == cmp_ref);
  assign add_base    = (phase == PH_FUNC) ? '0 : running_sum;
  assign sum_next    = add_base + rx_byte;
  assign count_next  = payload_count + fcp_pkg::LEN_W'(1);
  assign len_too_big = ({1'b0, rx_byte} >= LIMIT_CMP);

  assign out_free  = !out_valid || m_tready;
  assign emit_last = emit_single || ((emit_index + fcp_pkg::LEN_W'(1)) == frame_length);

  // Handshakes
  assign s_tready  = !rst && (state == ST_IDLE) && !(out_valid && (phase == PH_CSUM));
  assign cfg_ready = !rst;
  assign wr_en     = (state == ST_PARSE) && (phase == PH_DATA);
  assign rd_en     = (state == ST_READ);

  fcp_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (payload_count[ADDR_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (emit_index[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= fcp_pkg::SYNC_FIRST_RST;
      sync_second <= fcp_pkg::SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fcp_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_data;
        fcp_pkg::REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: parse one byte, then read out results
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_SYNC1;
      frame_function <= '0;
      frame_length   <= '0;
      payload_count  <= '0;
      running_sum    <= '0;
      emit_index     <= '0;
      emit_single    <= 1'b0;
      frame_ok       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Retire a taken result unless the next one loads in its place
      if (out_valid && m_tready && (state != ST_LOAD)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            rx_byte <= s_tdata;
            state   <= ST_PARSE;
          end
        end

        ST_PARSE: begin
          if (phase != PH_CSUM) begin
            state <= ST_IDLE;
          end
          unique case (phase)
            PH_SYNC1: phase <= cmp_match ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: phase <= cmp_match ? PH_FUNC : PH_SYNC1;
            PH_FUNC: begin
              if (fcp_pkg::func_valid(rx_byte)) begin
                frame_function <= rx_byte;
                running_sum    <= sum_next;
                phase          <= PH_LEN;
              end else begin
                phase <= PH_SYNC1;
              end
            end
            PH_LEN: begin
              if (len_too_big) begin
                // Retest this byte as a first sync byte
                phase <= cmp_match ? PH_SYNC2 : PH_SYNC1;
              end else begin
                frame_length  <= rx_byte[fcp_pkg::LEN_W-1:0];
                running_sum   <= sum_next;
                payload_count <= '0;
                phase <= (rx_byte[fcp_pkg::LEN_W-1:0] == '0) ? PH_CSUM : PH_DATA;
              end
            end
            PH_DATA: begin
              running_sum   <= sum_next;
              payload_count <= count_next;
              if (count_next >= frame_length) begin
                phase <= PH_CSUM;
              end
            end
            PH_CSUM: begin
              frame_ok   <= cmp_match;
              emit_index <= '0;
              if (cmp_match && (frame_length != '0)) begin
                emit_single <= 1'b0;
                state       <= ST_READ;
              end else begin
                emit_single <= 1'b1;
                state       <= ST_LOAD;
              end
            end
            default: phase <= PH_SYNC1;
          endcase
        end

        ST_READ: begin
          state <= ST_LOAD;
        end

        ST_LOAD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_ok       <= frame_ok;
            out_function <= frame_function;
            out_length   <= frame_length;
            out_payload  <= emit_single ? '0 : rd_data;
            out_position <= emit_single ? '0 : emit_index;
            out_last     <= emit_last;
            if (emit_last) begin
              // Close the frame and return to the hunt
              frame_function <= '0;
              frame_length   <= '0;
              payload_count  <= '0;
              running_sum    <= '0;
              phase          <= PH_SYNC1;
              state          <= ST_IDLE;
            end else begin
              emit_index <= emit_index + fcp_pkg::LEN_W'(1);
              state      <= ST_READ;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Drive the result stream
  assign m_tvalid = out_valid;
  assign m_tuser  = out_ok;
  assign m_tlast  = out_last;
  assign m_tdata  = {{PAD_W{1'b0}}, out_position, out_payload, out_length, out_function};

endmodule
